/* src/mc_pkg.sv */
// Package for the Morse code translator: character codes, the Morse table,
// and the types shared by the translator, run buffer and top level.
// No dependencies.
package mc_pkg;

    localparam int MAX_SYMBOLS = 5;
    localparam int RUN_MAX     = 6;
    localparam int TABLE_SIZE  = 36;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] len;
        logic [4:0] code;
    } entry_t;

    typedef struct packed {
        logic [4:0] symbols;
        logic [2:0] length;
        logic       invalid;
    } store_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [2:0]              count;
    } run_t;

    // Codes are written in sending order, dash as 1; bit 0 of the result is
    // the first symbol.
    function automatic entry_t mc_make(logic [7:0] ch, logic [2:0] len, logic [4:0] seq);
        entry_t e;
        e.ch  = ch;
        e.len = len;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            e.code[i] = seq[MAX_SYMBOLS-1-i];
        end
        return e;
    endfunction

    function automatic entry_t mc_entry(int k);
        entry_t e;
        case (k)
            0:  e = mc_make("A", 3'd2, 5'b01000);
            1:  e = mc_make("B", 3'd4, 5'b10000);
            2:  e = mc_make("C", 3'd4, 5'b10100);
            3:  e = mc_make("D", 3'd3, 5'b10000);
            4:  e = mc_make("E", 3'd1, 5'b00000);
            5:  e = mc_make("F", 3'd4, 5'b00100);
            6:  e = mc_make("G", 3'd3, 5'b11000);
            7:  e = mc_make("H", 3'd4, 5'b00000);
            8:  e = mc_make("I", 3'd2, 5'b00000);
            9:  e = mc_make("J", 3'd4, 5'b01110);
            10: e = mc_make("K", 3'd3, 5'b10100);
            11: e = mc_make("L", 3'd4, 5'b01000);
            12: e = mc_make("M", 3'd2, 5'b11000);
            13: e = mc_make("N", 3'd2, 5'b10000);
            14: e = mc_make("O", 3'd3, 5'b11100);
            15: e = mc_make("P", 3'd4, 5'b01100);
            16: e = mc_make("Q", 3'd4, 5'b11010);
            17: e = mc_make("R", 3'd3, 5'b01000);
            18: e = mc_make("S", 3'd3, 5'b00000);
            19: e = mc_make("T", 3'd1, 5'b10000);
            20: e = mc_make("U", 3'd3, 5'b00100);
            21: e = mc_make("V", 3'd4, 5'b00010);
            22: e = mc_make("W", 3'd3, 5'b01100);
            23: e = mc_make("X", 3'd4, 5'b10010);
            24: e = mc_make("Y", 3'd4, 5'b10110);
            25: e = mc_make("Z", 3'd4, 5'b11000);
            26: e = mc_make("1", 3'd5, 5'b01111);
            27: e = mc_make("2", 3'd5, 5'b00111);
            28: e = mc_make("3", 3'd5, 5'b00011);
            29: e = mc_make("4", 3'd5, 5'b00001);
            30: e = mc_make("5", 3'd5, 5'b00000);
            31: e = mc_make("6", 3'd5, 5'b10000);
            32: e = mc_make("7", 3'd5, 5'b11000);
            33: e = mc_make("8", 3'd5, 5'b11100);
            34: e = mc_make("9", 3'd5, 5'b11110);
            35: e = mc_make("0", 3'd5, 5'b11111);
            default: e = mc_make(CH_NONE, 3'd0, 5'b00000);
        endcase
        return e;
    endfunction

    // Returns the entry for a character, with length zero when there is none.
    function automatic entry_t mc_enc_find(logic [7:0] ch);
        entry_t e;
        entry_t r;
        r = mc_make(CH_NONE, 3'd0, 5'b00000);
        for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
            e = mc_entry(k);
            if (e.ch == ch) begin
                r = e;
            end
        end
        return r;
    endfunction

    // Returns the character for a stored code, or CH_NONE when none matches.
    function automatic logic [7:0] mc_dec_find(logic [2:0] len, logic [4:0] code);
        entry_t     e;
        logic [7:0] r;
        r = CH_NONE;
        for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
            e = mc_entry(k);
            if (e.len == len && e.code == code) begin
                r = e.ch;
            end
        end
        return r;
    endfunction

endpackage

/* src/mc_xlate.sv */
// Translator: turns one input byte into the run of result bytes it causes
// and the next decode store. Combinational; uses mc_pkg.
module mc_xlate
    import mc_pkg::*;
(
    input  logic       direction,
    input  logic [7:0] in_char,
    input  logic       end_of_message,
    input  store_t     store,
    output run_t       run,
    output store_t     store_next
);

    logic [7:0] up_char;
    entry_t     enc;
    logic       is_sym;
    logic       is_sep;
    logic       is_slash;
    logic       flush;
    store_t     upd;
    logic [7:0] hit_char;
    logic       hit;

    assign up_char  = (in_char >= CH_LOW_A && in_char <= CH_LOW_Z) ? in_char - CASE_OFS
                                                                    : in_char;
    assign enc      = mc_enc_find(up_char);
    assign is_sym   = (in_char == CH_DOT) || (in_char == CH_DASH);
    assign is_slash = (in_char == CH_SLASH);
    assign is_sep   = (in_char == CH_SPACE) || is_slash;
    assign flush    = is_sep || end_of_message;

    always_comb
    begin
        upd = store;
        if (is_sym) begin
            if (store.length < 3'(MAX_SYMBOLS)) begin
                if (in_char == CH_DASH) begin
                    upd.symbols = store.symbols | (5'(1) << store.length);
                end
                upd.length = store.length + 3'd1;
            end else begin
                upd.invalid = 1'b1;
            end
        end else if (!is_sep) begin
            upd.invalid = 1'b1;
        end
    end

    assign hit_char = mc_dec_find(upd.length, upd.symbols);
    assign hit      = flush && (upd.length != 3'd0) && !upd.invalid && (hit_char != CH_NONE);

    always_comb
    begin
        run.chars  = {RUN_MAX{CH_SPACE}};
        run.count  = 3'd0;
        store_next = store;
        if (!direction) begin
            if (up_char == CH_SPACE) begin
                run.chars[0] = CH_SLASH;
                run.count    = 3'd2;
            end else begin
                for (int i = 0; i < MAX_SYMBOLS; i++) begin
                    if (i < int'(enc.len)) begin
                        run.chars[i] = enc.code[i] ? CH_DASH : CH_DOT;
                    end
                end
                run.count = enc.len + 3'd1;
            end
        end else begin
            if (hit) begin
                run.chars[0] = hit_char;
            end
            run.count  = {2'b00, hit} + {2'b00, is_slash};
            store_next = flush ? '0 : upd;
        end
    end

endmodule

/* src/mc_run.sv */
// Run buffer: holds the result bytes of one input byte and hands them out
// one per transfer. Uses mc_pkg.
module mc_run
    import mc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  run_t       run_in,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    logic [RUN_MAX-1:0][7:0] chars_reg;
    logic [RUN_MAX-1:0][7:0] chars_next;
    logic [2:0]              count_reg;
    logic [2:0]              count_next;
    logic                    xfer;

    assign out_valid   = (count_reg != 3'd0);
    assign out_char    = chars_reg[0];
    assign last_of_run = (count_reg == 3'd1);
    assign xfer        = out_valid && out_ready;
    assign free        = !out_valid || (xfer && last_of_run);

    always_comb
    begin
        chars_next = chars_reg;
        count_next = count_reg;
        if (load) begin
            chars_next = run_in.chars;
            count_next = run_in.count;
        end else if (xfer) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                chars_next[i] = chars_reg[i+1];
            end
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

/* src/morse_codec.sv */
// Morse code translator top level: input register, direction register,
// decode store, translator and run buffer. Uses mc_pkg, mc_xlate, mc_run.
// The first result byte is offered from the run buffer once the input byte has
// passed through the input register and been loaded into a free run buffer.
// Throughput: one result byte per cycle while out_ready is high. An input byte
// causes zero to six results; the next one can load as the last result transfers.
// Reset clears the direction to encode, the decode store and all valid state.
module morse_codec
    import mc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    logic       direction_reg;
    logic       in_full_reg;
    logic [7:0] in_char_reg;
    logic       in_eom_reg;
    store_t     store_reg;
    store_t     store_next;
    run_t       run;
    logic       run_free;
    logic       take;
    logic       in_xfer;

    assign cfg_ready = 1'b1;
    assign take      = in_full_reg && run_free;
    assign in_ready  = !in_full_reg || take;
    assign in_xfer   = in_valid && in_ready;

    mc_xlate u_xlate (
        .direction      (direction_reg),
        .in_char        (in_char_reg),
        .end_of_message (in_eom_reg),
        .store          (store_reg),
        .run            (run),
        .store_next     (store_next)
    );

    mc_run u_run (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .run_in      (run),
        .free        (run_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= 1'b0;
            in_full_reg   <= 1'b0;
            store_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                direction_reg <= cfg_data;
            end
            if (in_xfer) begin
                in_full_reg <= 1'b1;
            end else if (take) begin
                in_full_reg <= 1'b0;
            end
            if (take) begin
                store_reg <= store_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            in_char_reg <= in_char;
            in_eom_reg  <= end_of_message;
        end
    end

`ifndef ASSERT_OFF
    a_encode_keeps_store: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !direction_reg) |=> $stable(store_reg))
        else $error("encode changed the decode store");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=> out_valid)
        else $error("run ended before its last byte");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> in_full_reg)
        else $error("accepted byte not held in input register");

    a_store_length: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (store_reg.length <= 3'(MAX_SYMBOLS)))
        else $error("decode store length out of range");
`endif

endmodule
